// ----- src/bnfa_pkg.sv -----
// Shared types, codes and helpers for the bitmap next-fit allocator.
package bnfa_pkg;

    localparam int WORD_BITS = 32;
    localparam int OFF_BITS  = 5;
    localparam int IDX_BITS  = 10;
    localparam int CFG_BITS  = 11;

    typedef enum logic [1:0] {
        REQ_TEST  = 2'd0,
        REQ_SET   = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_SCAN  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_INDEX   = 2'd1,
        ST_NO_FREE     = 2'd2,
        ST_BAD_POINTER = 2'd3
    } t_status;

    typedef struct packed {
        logic                hit;
        logic [OFF_BITS-1:0] idx;
    } t_first;

    function automatic t_first find_first(input logic [WORD_BITS-1:0] v);
        t_first r;
        r.hit = 1'b0;
        r.idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r.hit = 1'b1;
                r.idx = OFF_BITS'(i);
            end
        end
        return r;
    endfunction

endpackage

// ----- src/bnfa_bitmap.sv -----
// Word-wide bitmap memory with per-word valid bits that read as zero after reset.
module bnfa_bitmap #(
    parameter int NW = 32,
    parameter int AW = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [bnfa_pkg::WORD_BITS-1:0] o_rd_data,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [bnfa_pkg::WORD_BITS-1:0] i_wr_data
);
    import bnfa_pkg::*;

    logic [WORD_BITS-1:0] r_mem [0:NW-1];
    logic [NW-1:0]        r_vld;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rvld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rvld ? r_rdata : '0;

endmodule

// ----- src/bitmap_next_fit_allocator_core.sv -----
// Bitmap next-fit allocator: request control, scan sequencer and result register.
// Test, set and clear read the word on accept, then modify/write it and register the result;
// an out-of-range index or pointer returns its status in the cycle after accept.
// A scan reads one 32-bit word per cycle from the pointer's word, wrapping past the last word to word 0.
// One transaction is in flight at a time; the next is taken once the result is taken.
// Synchronous active-low reset empties the map (per-word valid bits), zeroes the
// pointer and sets the length to 1024 (capped at MAP_BITS); no clearing pass.
module bitmap_next_fit_allocator_core #(
    parameter int MAP_BITS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [9:0] bit_index
    input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [0] bit_value, [10:1] found_index
    output logic [1:0]  m_axis_tuser   // [1:0] status
);
    import bnfa_pkg::*;

    localparam int LEN_CAP = (MAP_BITS < 2048) ? MAP_BITS : 2048;
    localparam int PW      = $clog2(LEN_CAP);
    localparam int LW      = $clog2(LEN_CAP + 1);
    localparam int NW      = (LEN_CAP + WORD_BITS - 1) / WORD_BITS;
    localparam int AW      = (NW > 1) ? $clog2(NW) : 1;
    localparam int LEN_RST = (LEN_CAP < 1024) ? LEN_CAP : 1024;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN
    } t_state;

    t_state               r_state;
    t_req                 r_op;
    logic [OFF_BITS-1:0]  r_bit;
    logic [AW-1:0]        r_w;
    logic [AW-1:0]        r_w0;
    logic [OFF_BITS-1:0]  r_off;
    logic                 r_wrapped;
    logic [AW-1:0]        r_last_w;
    logic [OFF_BITS-1:0]  r_last_b;
    logic [PW-1:0]        r_ptr;
    logic [LW-1:0]        r_len;
    logic                 r_out_valid;
    t_status              r_status;
    logic                 r_value;
    logic [IDX_BITS-1:0]  r_found;

    logic                 accept;
    t_req                 in_req;
    logic [IDX_BITS-1:0]  in_idx;
    logic [PW-1:0]        in_pos;
    logic                 idx_bad;
    logic                 ptr_bad;
    logic [PW-1:0]        len_m1;
    logic [LW-1:0]        n_len;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;

    logic [WORD_BITS-1:0] cand;
    t_first               first;
    logic [PW-1:0]        hit_pos;
    logic [PW-1:0]        n_ptr;
    logic                 at_last;
    logic [AW-1:0]        n_w;
    logic                 scan_end;

    assign s_axis_tready = (r_state == S_IDLE) && !r_out_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_req        = t_req'(s_axis_tuser);
    assign in_idx        = s_axis_tdata[IDX_BITS-1:0];
    assign in_pos        = PW'(in_idx);
    assign idx_bad       = 32'(in_idx) >= 32'(r_len);
    assign ptr_bad       = 32'(r_ptr) >= 32'(r_len);
    assign len_m1        = PW'(32'(r_len) - 32'd1);
    assign n_len         = (32'(i_cfg_wdata) > LEN_CAP) ? LW'(LEN_CAP) : LW'(i_cfg_wdata);

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            cand[j] = !rd_data[j]
                && ((r_w != r_last_w) || (OFF_BITS'(j) <= r_last_b))
                && ((r_w != r_w0)
                    || (r_wrapped ? (OFF_BITS'(j) < r_off) : (OFF_BITS'(j) >= r_off)));
        end
    end

    assign first    = find_first(cand);
    assign hit_pos  = PW'({r_w, first.idx});
    assign n_ptr    = (32'(hit_pos) + 32'd1 == 32'(r_len)) ? '0 : PW'(32'(hit_pos) + 32'd1);
    assign at_last  = (r_w == r_last_w);
    assign n_w      = at_last ? '0 : AW'(32'(r_w) + 32'd1);
    assign scan_end = r_wrapped && (r_w == r_w0);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_data = rd_data;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_req == REQ_SCAN) begin
                        rd_en   = !ptr_bad;
                        rd_addr = AW'(r_ptr >> OFF_BITS);
                    end else begin
                        rd_en   = !idx_bad;
                        rd_addr = AW'(in_pos >> OFF_BITS);
                    end
                end
            end
            S_EVAL: begin
                wr_en          = (r_op != REQ_TEST);
                wr_data[r_bit] = (r_op == REQ_SET);
            end
            S_SCAN: begin
                rd_en   = !first.hit && !scan_end;
                rd_addr = n_w;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    bnfa_bitmap #(
        .NW(NW),
        .AW(AW)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_w),
        .i_wr_data (wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_len       <= LW'(LEN_RST);
            r_out_valid <= 1'b0;
            r_op        <= REQ_TEST;
            r_wrapped   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= n_len;
            end
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op      <= in_req;
                        r_value   <= 1'b0;
                        r_found   <= '0;
                        r_wrapped <= 1'b0;
                        r_last_w  <= AW'(len_m1 >> OFF_BITS);
                        r_last_b  <= OFF_BITS'(len_m1);
                        if (in_req == REQ_SCAN) begin
                            r_w  <= AW'(r_ptr >> OFF_BITS);
                            r_w0 <= AW'(r_ptr >> OFF_BITS);
                            r_off <= OFF_BITS'(r_ptr);
                            if (ptr_bad) begin
                                r_status    <= ST_BAD_POINTER;
                                r_out_valid <= 1'b1;
                            end else begin
                                r_status <= ST_OK;
                                r_state  <= S_SCAN;
                            end
                        end else begin
                            r_w   <= AW'(in_pos >> OFF_BITS);
                            r_bit <= OFF_BITS'(in_pos);
                            if (idx_bad) begin
                                r_status    <= ST_BAD_INDEX;
                                r_out_valid <= 1'b1;
                            end else begin
                                r_status <= ST_OK;
                                r_state  <= S_EVAL;
                            end
                        end
                    end
                end
                S_EVAL: begin
                    if (r_op == REQ_TEST) begin
                        r_value <= rd_data[r_bit];
                    end
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_SCAN: begin
                    if (first.hit) begin
                        r_found     <= IDX_BITS'(hit_pos);
                        r_ptr       <= n_ptr;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if (scan_end) begin
                        r_status    <= ST_NO_FREE;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_w <= n_w;
                        if (at_last) begin
                            r_wrapped <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {5'd0, r_found, r_value};

endmodule

// ----- tb/bitmap_next_fit_allocator_core_tb.sv -----
// Self-checking testbench for the bitmap next-fit allocator core.
module bitmap_next_fit_allocator_core_tb;
    import bnfa_pkg::*;

    localparam int MAP_SIZE       = 1024;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        t_status    status;
        logic       bit_value;
        logic [9:0] found_index;
    } t_alloc_result;

    class alloc_scoreboard;
        bit [MAP_SIZE-1:0] alloc_map;
        bit [9:0]          next_free;
        int unsigned       map_length;
        t_alloc_result     pending_results[$];
        t_alloc_result     last_result;
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       status_seen[4];

        function new();
            alloc_map  = '0;
            next_free  = '0;
            map_length = 1024;
            errors     = 0;
            checked    = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_length(logic [10:0] value);
            map_length = value;
        endfunction

        function t_alloc_result predict_result(t_req req, logic [9:0] idx);
            t_alloc_result r;
            int unsigned   len;
            int unsigned   pos;
            bit            hit;
            len = (map_length > MAP_SIZE) ? MAP_SIZE : map_length;
            r.status      = ST_OK;
            r.bit_value   = 1'b0;
            r.found_index = '0;
            hit = 1'b0;
            if (req == REQ_SCAN) begin
                if (next_free >= len) begin
                    r.status = ST_BAD_POINTER;
                end else begin
                    pos = next_free;
                    for (int i = 0; i < len; i++) begin
                        if (!hit && !alloc_map[pos]) begin
                            hit           = 1'b1;
                            r.found_index = 10'(pos);
                            next_free     = (pos + 1 == len) ? 10'd0 : 10'(pos + 1);
                        end
                        pos = (pos + 1 == len) ? 0 : pos + 1;
                    end
                    r.status = hit ? ST_OK : ST_NO_FREE;
                end
            end else if (idx >= len) begin
                r.status = ST_BAD_INDEX;
            end else begin
                case (req)
                    REQ_TEST: r.bit_value = alloc_map[idx];
                    REQ_SET:  alloc_map[idx] = 1'b1;
                    default:  alloc_map[idx] = 1'b0;
                endcase
            end
            return r;
        endfunction

        function void note_request(t_req req, logic [9:0] idx);
            last_result = predict_result(req, idx);
            pending_results.push_back(last_result);
        endfunction

        function void check_result(logic [15:0] tdata, logic [1:0] tuser);
            t_alloc_result want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing pending: status %0d data 0x%04h",
                         $time, tuser, tdata);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            status_seen[want.status]++;
            if (tuser != want.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, tuser);
            end
            if (tdata[0] != want.bit_value) begin
                errors++;
                $display("%0t: bit_value expected %0d actual %0d",
                         $time, want.bit_value, tdata[0]);
            end
            if (tdata[10:1] != want.found_index) begin
                errors++;
                $display("%0t: found_index expected %0d actual %0d",
                         $time, want.found_index, tdata[10:1]);
            end
        endfunction

        function int unsigned count();
            return pending_results.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [10:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [9:0] bit_index
    logic [1:0]  s_axis_tuser;   // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;   // [0] bit_value, [10:1] found_index
    logic [1:0]  m_axis_tuser;   // [1:0] status

    alloc_scoreboard sb;
    bit              no_idle = 1'b0;
    int unsigned     ready_hold = 0;
    int unsigned     quiet_cycles = 0;

    bitmap_next_fit_allocator_core #(
        .MAP_BITS(MAP_SIZE)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        int unsigned r;
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (no_idle) begin
            m_axis_tready = 1'b1;
        end else begin
            r = $urandom_range(99);
            if (r < 60) begin
                m_axis_tready = 1'b1;
                ready_hold    = $urandom_range(5);
            end else if (r < 92) begin
                m_axis_tready = 1'b0;
                ready_hold    = $urandom_range(2);
            end else begin
                m_axis_tready = 1'b0;
                ready_hold    = $urandom_range(40, 10);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_request(input t_req req, input logic [9:0] idx);
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = req;
        s_axis_tdata  = {6'd0, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(req, idx);
    endtask

    task automatic issue(input t_req req, input logic [9:0] idx);
        int unsigned r;
        int unsigned gap;
        send_request(req, idx);
        r = $urandom_range(99);
        if (no_idle || r < 65)
            gap = 0;
        else if (r < 93)
            gap = $urandom_range(3, 1);
        else
            gap = $urandom_range(40, 8);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.count() != 0) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [10:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.set_length(value);
    endtask

    task automatic run_phase(input logic [10:0] len, input int n_items);
        int unsigned r;
        int unsigned eff;
        t_req        req;
        logic [9:0]  idx;
        bit          follow_alloc;
        write_length(len);
        no_idle      = ($urandom_range(3) == 0);
        eff          = (len > MAP_SIZE) ? MAP_SIZE : len;
        follow_alloc = 1'b0;
        for (int n = 0; n < n_items; n++) begin
            if (follow_alloc && $urandom_range(1)) begin
                req = REQ_SET;
                idx = sb.last_result.found_index;
            end else begin
                r = $urandom_range(99);
                if (r < 20)
                    req = REQ_TEST;
                else if (r < 55)
                    req = REQ_SET;
                else if (r < 70)
                    req = REQ_CLEAR;
                else
                    req = REQ_SCAN;
                r = $urandom_range(99);
                if (eff > 0 && r < 80)
                    idx = 10'($urandom_range(eff - 1, 0));
                else if (eff > 0 && r < 88)
                    idx = 10'(eff - 1);
                else
                    idx = 10'($urandom());
            end
            issue(req, idx);
            follow_alloc = (req == REQ_SCAN) && (sb.last_result.status == ST_OK);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_TEST;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        issue(REQ_TEST, 10'd0);
        issue(REQ_SET, 10'd0);
        issue(REQ_TEST, 10'd0);
        issue(REQ_SET, 10'd1023);
        issue(REQ_TEST, 10'd1023);
        issue(REQ_SCAN, 10'd0);
        issue(REQ_CLEAR, 10'd0);
        issue(REQ_TEST, 10'd0);
        issue(REQ_CLEAR, 10'd1023);
        issue(REQ_SCAN, 10'd1023);

        // zero length: every index and the pointer fall out of range
        write_length(11'd0);
        issue(REQ_TEST, 10'd5);
        issue(REQ_SCAN, 10'd0);
        issue(REQ_SET, 10'd1023);

        // pointer sits beyond a length of one
        write_length(11'd1);
        issue(REQ_SCAN, 10'd0);

        // fill a four-bit map, then free one bit
        write_length(11'd4);
        issue(REQ_SCAN, 10'd0);
        issue(REQ_SET, 10'd0);
        issue(REQ_SET, 10'd1);
        issue(REQ_SET, 10'd2);
        issue(REQ_SET, 10'd3);
        issue(REQ_SCAN, 10'd0);
        issue(REQ_CLEAR, 10'd2);
        issue(REQ_SCAN, 10'd0);

        // length above the map size is capped
        write_length(11'd2047);
        issue(REQ_TEST, 10'd1023);
        issue(REQ_SCAN, 10'd0);
        issue(REQ_TEST, 10'd682);

        run_phase(11'd2047, 50);
        run_phase(11'd8, 45);
        run_phase(11'd1, 20);
        run_phase(11'd33, 45);
        run_phase(11'd1024, 50);
        run_phase(11'd0, 15);
        run_phase(11'd100, 45);
        run_phase(11'd5, 35);
        run_phase(11'($urandom_range(1023, 1)), 45);
        run_phase(11'd1000, 45);
        run_phase(11'd32, 45);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d results checked: %0d ok, %0d bad index, %0d map full, %0d bad pointer",
                 sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_BAD_INDEX],
                 sb.status_seen[ST_NO_FREE], sb.status_seen[ST_BAD_POINTER]);
        $display("map lengths swept from 0 to 2047 with random stalls on both streams");
        if (sb.errors == 0 && sb.count() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/bnfa_pkg.sv
src/bnfa_bitmap.sv
src/bitmap_next_fit_allocator_core.sv
tb/bitmap_next_fit_allocator_core_tb.sv
